// ----- rtl/sof_length_xor_frame_parser_defines.svh -----
// Assertion macros for the frame parser, empty when synthesised.
`ifndef SOF_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH
`define SOF_LENGTH_XOR_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define SOFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SOFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SOFP_ASSERT(lbl, prop, msg)
`define SOFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/sofp_pkg.sv -----
// Shared types and constants of the frame parser.
package sofp_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_START_BYTE = 1'b0;

  localparam logic [7:0] START_BYTE_RESET = 8'hFE;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        check_ok;
    logic [15:0] command;
    logic [15:0] dest_addr;
    logic [7:0]  payload_len;
  } sofp_result_t;

endpackage

// ----- rtl/sofp_cfg.sv -----
// Configuration register file holding the start byte.
module sofp_cfg
  import sofp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [7:0]        start_byte
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (wr_en && (reg_index == REG_START_BYTE)) begin
      start_byte <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_START_BYTE: prdata = {{(DATA_W-8){1'b0}}, start_byte};
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/sofp_parser.sv -----
// Frame field sequencer with running XOR check and result formation.
module sofp_parser
  import sofp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   start_byte,
  output logic         res_valid,
  output sofp_result_t res
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_CMDL = 3'd2,
    PH_CMDH = 3'd3,
    PH_DSTL = 3'd4,
    PH_DSTH = 3'd5,
    PH_DATA = 3'd6,
    PH_CHK  = 3'd7
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  received_count, received_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] command_word, command_word_next;
  logic [15:0] dest_word, dest_word_next;
  logic [7:0]  count_inc;

  assign count_inc = received_count + 8'd1;

  always_comb begin
    phase_next          = phase;
    frame_len_next      = frame_len;
    received_count_next = received_count;
    running_xor_next    = running_xor;
    command_word_next   = command_word;
    dest_word_next      = dest_word;
    res_valid           = 1'b0;
    res                 = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == start_byte) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_len_next      = rx_byte;
        received_count_next = 8'd0;
        running_xor_next    = rx_byte;
        command_word_next   = 16'd0;
        dest_word_next      = 16'd0;
        phase_next          = PH_CMDL;
      end
      PH_CMDL: begin
        command_word_next = {command_word[15:8], rx_byte};
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_CMDH;
      end
      PH_CMDH: begin
        command_word_next = {rx_byte, command_word[7:0]};
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_DSTL;
      end
      PH_DSTL: begin
        dest_word_next   = {dest_word[15:8], rx_byte};
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = PH_DSTH;
      end
      PH_DSTH: begin
        dest_word_next   = {rx_byte, dest_word[7:0]};
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = (frame_len != 8'd0) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        res_valid           = 1'b1;
        res.kind            = KIND_PAYLOAD;
        res.data_byte       = rx_byte;
        res.byte_index      = received_count;
        running_xor_next    = running_xor ^ rx_byte;
        received_count_next = count_inc;
        if (count_inc == frame_len) begin
          phase_next = PH_CHK;
        end
      end
      PH_CHK: begin
        res_valid       = 1'b1;
        res.kind        = KIND_FRAME_END;
        res.check_ok    = (running_xor == rx_byte);
        res.command     = command_word;
        res.dest_addr   = dest_word;
        res.payload_len = frame_len;
        phase_next      = PH_HUNT;
      end
    endcase
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      frame_len      <= 8'd0;
      received_count <= 8'd0;
      running_xor    <= 8'd0;
      command_word   <= 16'd0;
      dest_word      <= 16'd0;
    end else if (step) begin
      phase          <= phase_next;
      frame_len      <= frame_len_next;
      received_count <= received_count_next;
      running_xor    <= running_xor_next;
      command_word   <= command_word_next;
      dest_word      <= dest_word_next;
    end
  end

endmodule

// ----- rtl/sofp_out_skid.sv -----
// Output register with a skid entry that absorbs one word while the sink stalls.
module sofp_out_skid
  import sofp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sofp_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output sofp_result_t out_data
);

  logic         skid_valid;
  sofp_result_t skid_data;
  logic         slot_free;

  assign full      = skid_valid;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

// ----- rtl/sof_length_xor_frame_parser.sv -----
// Frame parser top level: hunts for the start byte and reads length, command,
// destination, payload and check byte, one received byte per word. It takes a
// new byte in every clock cycle unless in_stall is high; a payload word or
// frame-end word for that byte appears in the output register on the next
// cycle when the sink is not stalling, and otherwise waits in the skid entry.
// The rate is set by the field sequencer, whose state is updated once per
// accepted byte. An output register and one skid entry part the two sides, so
// the input is stalled only when both hold words the sink has not yet taken.
// The start byte is register 0 at byte address 0 and resets to 0xFE.
`include "sof_length_xor_frame_parser_defines.svh"

module sof_length_xor_frame_parser
  import sofp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [7:0]        data_byte,
  output logic [7:0]        byte_index,
  output logic              check_ok,
  output logic [15:0]       command,
  output logic [15:0]       dest_addr,
  output logic [7:0]        payload_len
);

  logic         in_accept;
  logic [7:0]   start_byte;
  logic         res_valid;
  sofp_result_t res;
  sofp_result_t out_data;

  assign in_accept = in_valid && !in_stall;

  sofp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_byte (start_byte)
  );

  sofp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (in_accept),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  sofp_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind        = out_data.kind;
  assign data_byte   = out_data.data_byte;
  assign byte_index  = out_data.byte_index;
  assign check_ok    = out_data.check_ok;
  assign command     = out_data.command;
  assign dest_addr   = out_data.dest_addr;
  assign payload_len = out_data.payload_len;

  `SOFP_ASSERT(a_skid_implies_out, in_stall |-> out_valid, "skid entry held with empty output")
  `SOFP_ASSERT_ALWAYS(a_push_only_on_accept, res_valid |-> in_accept,
                      "result without accepted byte")
  `SOFP_ASSERT(a_frame_end_clean,
               (out_valid && kind == KIND_FRAME_END) |->
               (data_byte == 8'd0 && byte_index == 8'd0),
               "frame-end word carries payload fields")
  `SOFP_ASSERT(a_payload_clean,
               (out_valid && kind == KIND_PAYLOAD) |->
               (!check_ok && command == 16'd0 && payload_len == 8'd0),
               "payload word carries frame-end fields")

endmodule

// ----- bench/sof_length_xor_frame_parser_tb.sv -----
// Self-checking bench for the frame parser: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module sof_length_xor_frame_parser_tb;
  import sofp_pkg::*;

  localparam logic [ADDR_W-1:0] START_BYTE_ADDR = ADDR_W'(4 * REG_START_BYTE);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR     = ADDR_W'(4);
  localparam int                ITEMS_PER_PHASE = 180;
  localparam int                SETTLE_CYCLES   = 4;

  typedef enum logic [2:0] {
    ST_HUNT, ST_LENGTH, ST_CMD_LO, ST_CMD_HI, ST_DEST_LO, ST_DEST_HI, ST_BODY, ST_CHECK
  } frame_phase_t;

  class frame_tracker;
    logic [7:0]   start_byte;
    frame_phase_t phase;
    logic [7:0]   frame_len;
    logic [7:0]   rx_count;
    logic [7:0]   xor_acc;
    logic [15:0]  cmd_word;
    logic [15:0]  dst_word;
    sofp_result_t expected_words[$];
    int           errors;
    int           words_checked;
    int           frame_ends;
    int           bad_checks;

    function new();
      start_byte    = START_BYTE_RESET;
      phase         = ST_HUNT;
      frame_len     = '0;
      rx_count      = '0;
      xor_acc       = '0;
      cmd_word      = '0;
      dst_word      = '0;
      errors        = 0;
      words_checked = 0;
      frame_ends    = 0;
      bad_checks    = 0;
    endfunction

    function void set_start(logic [7:0] value);
      start_byte = value;
    endfunction

    function void accept_byte(logic [7:0] b);
      sofp_result_t w;
      w = '0;
      case (phase)
        ST_HUNT: begin
          if (b == start_byte) phase = ST_LENGTH;
        end
        ST_LENGTH: begin
          frame_len = b;
          rx_count  = '0;
          xor_acc   = b;
          cmd_word  = '0;
          dst_word  = '0;
          phase     = ST_CMD_LO;
        end
        ST_CMD_LO: begin
          cmd_word[7:0] = b;
          xor_acc ^= b;
          phase = ST_CMD_HI;
        end
        ST_CMD_HI: begin
          cmd_word[15:8] = b;
          xor_acc ^= b;
          phase = ST_DEST_LO;
        end
        ST_DEST_LO: begin
          dst_word[7:0] = b;
          xor_acc ^= b;
          phase = ST_DEST_HI;
        end
        ST_DEST_HI: begin
          dst_word[15:8] = b;
          xor_acc ^= b;
          phase = (frame_len != 8'd0) ? ST_BODY : ST_CHECK;
        end
        ST_BODY: begin
          w.kind       = KIND_PAYLOAD;
          w.data_byte  = b;
          w.byte_index = rx_count;
          xor_acc ^= b;
          rx_count = rx_count + 8'd1;
          if (rx_count == frame_len) phase = ST_CHECK;
          expected_words.push_back(w);
        end
        default: begin
          w.kind        = KIND_FRAME_END;
          w.check_ok    = (xor_acc == b);
          w.command     = cmd_word;
          w.dest_addr   = dst_word;
          w.payload_len = frame_len;
          frame_ends++;
          if (!w.check_ok) bad_checks++;
          phase = ST_HUNT;
          expected_words.push_back(w);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("word %0d field %s: got 0x%0h, wanted 0x%0h",
                                  words_checked, name, got, want));
    endtask

    task check_word(sofp_result_t got);
      sofp_result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = expected_words.pop_front();
        compare_field("kind", 16'(got.kind), 16'(want.kind));
        compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
        compare_field("byte_index", 16'(got.byte_index), 16'(want.byte_index));
        compare_field("check_ok", 16'(got.check_ok), 16'(want.check_ok));
        compare_field("command", got.command, want.command);
        compare_field("dest_addr", got.dest_addr, want.dest_addr);
        compare_field("payload_len", 16'(got.payload_len), 16'(want.payload_len));
      end
      words_checked++;
    endtask
  endclass

  logic              clk;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              kind;
  logic [7:0]        data_byte;
  logic [7:0]        byte_index;
  logic              check_ok;
  logic [15:0]       command;
  logic [15:0]       dest_addr;
  logic [7:0]        payload_len;

  frame_tracker tracker = new();
  logic [7:0]   tx_q[$];
  int           bytes_queued   = 0;
  int           bytes_accepted = 0;
  bit           steady         = 1'b0;
  logic [7:0]   frame_start    = START_BYTE_RESET;
  int           hold_left      = 0;
  bit           hold_done      = 1'b0;
  sofp_result_t seen;

  sof_length_xor_frame_parser dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .check_ok   (check_ok),
    .command    (command),
    .dest_addr  (dest_addr),
    .payload_len(payload_len)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("sof_length_xor_frame_parser_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tracker.accept_byte(rx_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_q.size() > 0 && (steady || $urandom_range(99) >= 10)) begin
          in_valid <= 1'b1;
          rx_byte  <= tx_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind        = kind;
        seen.data_byte   = data_byte;
        seen.byte_index  = byte_index;
        seen.check_ok    = check_ok;
        seen.command     = command;
        seen.dest_addr   = dest_addr;
        seen.payload_len = payload_len;
        tracker.check_word(seen);
      end
      // One long hold-off so that the output register and skid entry fill and the input stalls.
      if (!hold_done && tracker.words_checked >= 60) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 10);
      end
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_start_byte(input logic [7:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= START_BYTE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(want))
      tracker.report_mismatch($sformatf("start byte read 0x%0h, wanted 0x%0h", prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_start_byte(input logic [7:0] value);
    reg_write(START_BYTE_ADDR, DATA_W'(value));
    tracker.set_start(value);
    frame_start = value;
    read_start_byte(value);
  endtask

  task automatic push_byte(input logic [7:0] b);
    tx_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == frame_start);
    push_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] cmd, input logic [15:0] dst,
                            input logic [7:0] body[$], input bit corrupt);
    logic [7:0] sum;
    sum = 8'(body.size()) ^ cmd[7:0] ^ cmd[15:8] ^ dst[7:0] ^ dst[15:8];
    foreach (body[i]) sum ^= body[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    push_byte(frame_start);
    push_byte(8'(body.size()));
    push_byte(cmd[7:0]);
    push_byte(cmd[15:8]);
    push_byte(dst[7:0]);
    push_byte(dst[15:8]);
    foreach (body[i]) push_byte(body[i]);
    push_byte(sum);
  endtask

  task automatic random_frame(input int len);
    logic [7:0] body[$];
    repeat (len) body.push_back(8'($urandom_range(255)));
    send_frame(16'($urandom), 16'($urandom), body, $urandom_range(99) < 12);
  endtask

  task automatic random_traffic(input int budget);
    int base;
    int pick;
    int n;
    base = bytes_queued;
    while (bytes_queued - base < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Bytes dropped while hunting do not count towards the budget.
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_noise();
          base++;
        end
      end else if (pick < 13) begin
        // A frame cut short; whatever follows is taken as its fields.
        push_byte(frame_start);
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) n = 255;
        else if (pick < 15) n = $urandom_range(13, 64);
        else n = $urandom_range(0, 12);
        random_frame(n);
      end
    end
  endtask

  task automatic drain(input int settle);
    int waited;
    waited = 0;
    while (bytes_accepted != bytes_queued) @(posedge clk);
    while (tracker.expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [7:0] body[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_start_byte(START_BYTE_RESET);

    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    body.delete();
    send_frame(16'h0000, 16'h0000, body, 1'b0);
    body = '{8'hFF, 8'hFE};
    send_frame(16'hFFFF, 16'hFFFF, body, 1'b0);
    body.delete();
    send_frame(16'h1234, 16'hABCD, body, 1'b1);
    drain(SETTLE_CYCLES);

    random_traffic(ITEMS_PER_PHASE);
    drain(SETTLE_CYCLES);

    set_start_byte(8'h00);
    steady = 1'b1;
    random_traffic(ITEMS_PER_PHASE);
    drain(SETTLE_CYCLES);
    steady = 1'b0;

    set_start_byte(8'hFF);
    random_frame(255);
    random_traffic(ITEMS_PER_PHASE);
    drain(SETTLE_CYCLES);

    reg_write(UNUSED_ADDR, DATA_W'($urandom));
    read_start_byte(frame_start);
    set_start_byte(8'($urandom_range(1, 254)));
    random_traffic(ITEMS_PER_PHASE);
    drain(SETTLE_CYCLES);

    set_start_byte(START_BYTE_RESET);
    random_traffic(ITEMS_PER_PHASE);
    drain(2 * SETTLE_CYCLES);

    if (tracker.expected_words.size() != 0)
      tracker.report_mismatch($sformatf("%0d words never arrived",
                                        tracker.expected_words.size()));
    $display("Covered %0d bytes in, %0d words out, %0d frame ends (%0d with a bad check byte).",
             bytes_accepted, tracker.words_checked, tracker.frame_ends, tracker.bad_checks);
    $display("Start byte set to reset, low, high and random values; %0d mismatches.",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("sof_length_xor_frame_parser_tb: done, clean");
    end else begin
      $display("sof_length_xor_frame_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
